// File: rtl/bgf_pkg.sv
package bgf_pkg;

    // Widths fixed by the item fields
    localparam int ACCESS_BITS = 32;
    localparam int PTR_W       = 13;
    localparam int CNT_W       = 6;
    localparam int CAP_W       = 10;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_CAPACITY  = 2'd2
    } t_status;

    // Controls for the two-word bit aligner
    typedef struct packed {
        logic [4:0]       offset;
        logic [CNT_W-1:0] wr_count;
        logic [CNT_W-1:0] rd_count;
    } t_align_ctl;

    // Ones in the low 'count' bits; count of 32 or more gives all ones
    function automatic logic [ACCESS_BITS-1:0] f_low_mask(input logic [CNT_W-1:0] count);
        logic [ACCESS_BITS-1:0] m;
        if (count >= CNT_W'(ACCESS_BITS)) begin
            m = '1;
        end else begin
            m = (ACCESS_BITS'(1) << count) - ACCESS_BITS'(1);
        end
        return m;
    endfunction

endpackage

// File: rtl/bgf_bank.sv
module bgf_bank
    import bgf_pkg::*;
#(
    parameter int DEPTH = 65,
    parameter int AW    = 7
) (
    input  logic                   i_clk,
    input  logic [AW-1:0]          i_addr,
    input  logic                   i_re,
    input  logic                   i_we,
    input  logic [ACCESS_BITS-1:0] i_wdata,
    output logic [ACCESS_BITS-1:0] o_rdata
);

    logic [ACCESS_BITS-1:0] r_mem [DEPTH];
    logic [ACCESS_BITS-1:0] r_rdata;

    // Single port word store, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bgf_align.sv
module bgf_align
    import bgf_pkg::*;
(
    input  t_align_ctl             i_ctl,
    input  logic [ACCESS_BITS-1:0] i_lo_word,
    input  logic [ACCESS_BITS-1:0] i_hi_word,
    input  logic [ACCESS_BITS-1:0] i_write_data,
    output logic [ACCESS_BITS-1:0] o_read_data,
    output logic [ACCESS_BITS-1:0] o_lo_word,
    output logic [ACCESS_BITS-1:0] o_hi_word,
    output logic                   o_hi_touched
);

    logic [2*ACCESS_BITS-1:0] pair;
    logic [2*ACCESS_BITS-1:0] extracted;
    logic [2*ACCESS_BITS-1:0] ins_bits;
    logic [2*ACCESS_BITS-1:0] ins_mask;
    logic [2*ACCESS_BITS-1:0] merged;

    // Extract: shift the word pair down to the bit offset, keep the read count
    always_comb begin
        pair        = {i_hi_word, i_lo_word};
        extracted   = pair >> i_ctl.offset;
        o_read_data = extracted[ACCESS_BITS-1:0] & f_low_mask(i_ctl.rd_count);
    end

    // Insert: place the new bits at the offset and merge with the old words
    always_comb begin
        ins_mask     = {{ACCESS_BITS{1'b0}}, f_low_mask(i_ctl.wr_count)} << i_ctl.offset;
        ins_bits     = {{ACCESS_BITS{1'b0}}, i_write_data & f_low_mask(i_ctl.wr_count)}
                       << i_ctl.offset;
        merged       = (pair & ~ins_mask) | ins_bits;
        o_lo_word    = merged[ACCESS_BITS-1:0];
        o_hi_word    = merged[2*ACCESS_BITS-1:ACCESS_BITS];
        o_hi_touched = |ins_mask[2*ACCESS_BITS-1:ACCESS_BITS];
    end

endmodule

// File: rtl/bit_granular_fifo_buffer_top.sv
// Bit-granular FIFO buffer, least significant bit first.
// Input channel (i_valid / o_stall) carries one command item: write bits,
// read bits, seek the read pointer or clear both pointers. Output channel
// (o_valid / i_stall) returns exactly one result item per command with the
// read data, bit count done, status, occupancy, empty and full flags.
// The store is two 32-bit word banks (even and odd words), so any unaligned
// access of up to 32 bits reaches both of its words in one read cycle.
// Each item first reads the word pair from the banks at the edge that
// accepts it, then merges, writes back and updates the pointers in S_EXEC.
// o_valid is set when S_EXEC finishes; o_stall stays high in S_EXEC, so a
// new item is taken only once the last one is through.
// When the receiver stalls, the result waits in the output register; the
// next item is still accepted and waits in the merge cycle until the output
// register frees up. The user must write the capacity register (i_cfg_we /
// i_cfg_data) only while the block is idle; the block does not enforce it.
// Reset clears both pointers, drops any pending result and sets the
// capacity to 512 bytes (or the store size if smaller). Store contents are
// not cleared; only written bits are ever read.
module bit_granular_fifo_buffer_top
    import bgf_pkg::*;
#(
    parameter int STORE_BYTES = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CAP_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_command,
    input  logic [ACCESS_BITS-1:0] i_write_data,
    input  logic [CNT_W-1:0]       i_bit_count,
    input  logic [PTR_W-1:0]       i_seek_offset,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ACCESS_BITS-1:0] o_read_data,
    output logic [CNT_W-1:0]       o_bits_done,
    output logic [1:0]             o_status,
    output logic [PTR_W-1:0]       o_occupancy,
    output logic                   o_is_empty,
    output logic                   o_is_full
);

    localparam int BANK_DEPTH   = (STORE_BYTES + 7) / 8 + 1;
    localparam int BA_W         = $clog2(BANK_DEPTH);
    localparam int RST_BYTES    = (STORE_BYTES < 512) ? STORE_BYTES : 512;
    localparam int MAX_BYTES    = (STORE_BYTES < 1023) ? STORE_BYTES : 1023;
    localparam logic [PTR_W-1:0] CAP_RST_BITS = PTR_W'(RST_BYTES * 8);
    localparam logic [PTR_W-1:0] CAP_MAX_BITS = PTR_W'(MAX_BYTES * 8);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [PTR_W-1:0]       r_wp, n_wp;
    logic [PTR_W-1:0]       r_rp, n_rp;
    logic [PTR_W-1:0]       r_cap_bits;
    logic [1:0]             r_cmd;
    logic [ACCESS_BITS-1:0] r_wdata;
    logic [CNT_W-1:0]       r_cnt;
    logic [PTR_W-1:0]       r_seek;
    logic                   r_out_valid;
    logic [ACCESS_BITS-1:0] r_out_rdata;
    logic [CNT_W-1:0]       r_out_done;
    t_status                r_out_status;
    logic [PTR_W-1:0]       r_out_occ;
    logic                   r_out_empty;
    logic                   r_out_full;

    logic                   in_take;
    logic                   finish;
    logic [1:0]             acc_cmd;
    logic [PTR_W-1:0]       acc_ptr;
    logic [BA_W-1:0]        addr0, addr1;
    logic [ACCESS_BITS-1:0] rd0, rd1, wd0, wd1;
    logic                   we0, we1;
    logic                   odd_word;
    logic [ACCESS_BITS-1:0] lo_word, hi_word, new_lo, new_hi, ext_data;
    logic                   hi_touched;
    t_align_ctl             align_ctl;
    logic [PTR_W-1:0]       avail;
    logic [CNT_W-1:0]       rd_n;
    logic                   wr_ok;
    logic [CNT_W-1:0]       n_done;
    t_status                n_status;
    logic [ACCESS_BITS-1:0] n_rdata;

    assign in_take = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign finish  = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    // Pointer of the access: read pointer for reads, write pointer otherwise
    assign acc_cmd = (r_state == S_IDLE) ? i_command : r_cmd;
    assign acc_ptr = (acc_cmd == CMD_READ) ? r_rp : r_wp;

    // Word pair split over even/odd banks; odd low word pushes bank 0 up one
    always_comb begin
        odd_word = acc_ptr[5];
        addr1    = BA_W'(acc_ptr[PTR_W-1:6]);
        addr0    = BA_W'({1'b0, acc_ptr[PTR_W-1:6]} + {7'd0, odd_word});
    end

    assign lo_word = odd_word ? rd1 : rd0;
    assign hi_word = odd_word ? rd0 : rd1;

    // Command execution in the merge cycle
    always_comb begin
        avail    = r_wp - r_rp;
        rd_n     = ({7'd0, r_cnt} > avail) ? CNT_W'(avail) : r_cnt;
        wr_ok    = ({1'b0, r_wp} + {8'd0, r_cnt}) <= {1'b0, r_cap_bits};
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_done   = '0;
        n_status = ST_OK;
        n_rdata  = '0;
        we0      = 1'b0;
        we1      = 1'b0;
        case (r_cmd)
            CMD_WRITE: begin
                if (r_cnt == '0) begin
                    n_status = ST_BAD_COUNT;
                end else if (!wr_ok) begin
                    n_status = ST_CAPACITY;
                end else begin
                    n_wp   = r_wp + PTR_W'(r_cnt);
                    n_done = r_cnt;
                    we0    = finish && (odd_word ? hi_touched : 1'b1);
                    we1    = finish && (odd_word ? 1'b1 : hi_touched);
                end
            end
            CMD_READ: begin
                if (r_cnt == '0) begin
                    n_status = ST_BAD_COUNT;
                end else begin
                    n_rp    = r_rp + PTR_W'(rd_n);
                    n_done  = rd_n;
                    n_rdata = ext_data;
                end
            end
            CMD_SEEK: begin
                n_rp = (r_seek >= r_wp) ? r_wp : r_seek;
            end
            default: begin
                n_wp = '0;
                n_rp = '0;
            end
        endcase
    end

    assign align_ctl = '{offset: acc_ptr[4:0], wr_count: r_cnt, rd_count: rd_n};
    assign wd0       = odd_word ? new_hi : new_lo;
    assign wd1       = odd_word ? new_lo : new_hi;

    bgf_align u_align (
        .i_ctl        (align_ctl),
        .i_lo_word    (lo_word),
        .i_hi_word    (hi_word),
        .i_write_data (r_wdata),
        .o_read_data  (ext_data),
        .o_lo_word    (new_lo),
        .o_hi_word    (new_hi),
        .o_hi_touched (hi_touched)
    );

    bgf_bank #(.DEPTH(BANK_DEPTH), .AW(BA_W)) u_bank_even (
        .i_clk   (i_clk),
        .i_addr  (addr0),
        .i_re    (in_take),
        .i_we    (we0),
        .i_wdata (wd0),
        .o_rdata (rd0)
    );

    bgf_bank #(.DEPTH(BANK_DEPTH), .AW(BA_W)) u_bank_odd (
        .i_clk   (i_clk),
        .i_addr  (addr1),
        .i_re    (in_take),
        .i_we    (we1),
        .i_wdata (wd1),
        .o_rdata (rd1)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_take) n_state = S_EXEC;
            S_EXEC:  if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, pointers, capacity, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cap_bits  <= CAP_RST_BITS;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (32'(i_cfg_data) > STORE_BYTES) begin
                    r_cap_bits <= CAP_MAX_BITS;
                end else begin
                    r_cap_bits <= {i_cfg_data, 3'b000};
                end
            end
            if (finish) begin
                r_wp        <= n_wp;
                r_rp        <= n_rp;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture, count saturated to the access width
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd   <= i_command;
            r_wdata <= i_write_data;
            r_cnt   <= (i_bit_count > CNT_W'(ACCESS_BITS)) ? CNT_W'(ACCESS_BITS) : i_bit_count;
            r_seek  <= i_seek_offset;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_rdata  <= n_rdata;
            r_out_done   <= n_done;
            r_out_status <= n_status;
            r_out_occ    <= n_wp - n_rp;
            r_out_empty  <= (n_wp == n_rp);
            r_out_full   <= (n_wp == r_cap_bits);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_bits_done = r_out_done;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;
    assign o_is_empty  = r_out_empty;
    assign o_is_full   = r_out_full;

endmodule
